// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL; the top-level module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== rtl/tdcfa_pkg.sv =====
// Types, constants and helpers for the time-of-day clock with feed alarms.
package tdcfa_pkg;

  localparam int NUM_ALARMS_DEF = 3;
  localparam int ALARM_W = 20;
  localparam int CFG_IDX_W = 2;
  localparam int HOUR_W = 5;
  localparam int MIN_W = 6;
  localparam int SEC_W = 6;
  localparam int BCD_W = 8;
  localparam int FEED_W = 8;

  localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);
  localparam logic [MIN_W-1:0] MIN_MAX = MIN_W'(59);
  localparam logic [SEC_W-1:0] SEC_MAX = SEC_W'(59);
  localparam logic [SEC_W-1:0] SEC_RESYNC = SEC_W'(45);

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RTC_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_BASE = 2'd1;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0] minute;
    logic [SEC_W-1:0] second;
  } tod_t;

  typedef struct packed {
    logic [FEED_W-1:0] feed;
    logic armed;
    logic [MIN_W-1:0] minute;
    logic [HOUR_W-1:0] hour;
  } alarm_t;

  typedef struct packed {
    tod_t tod;
    logic minute_roll;
  } tick_res_t;

  typedef struct packed {
    logic fired;
    logic [FEED_W-1:0] amount;
  } match_t;

  function automatic logic [BCD_W-1:0] bcd_dec(input logic [BCD_W-1:0] v,
                                               input logic [BCD_W-1:0] limit);
    logic [BCD_W-1:0] d;
    d = ({4'd0, v[7:4]} << 3) + ({4'd0, v[7:4]} << 1) + {4'd0, v[3:0]};
    return (d > limit) ? limit : d;
  endfunction

endpackage

// ===== rtl/tdcfa_time.sv =====
// Next time of day: one-second tick with cascaded wrap and BCD resync; a check holds the time.
module tdcfa_time
  import tdcfa_pkg::*;
(
  input  tod_t             cur,
  input  logic             operation,
  input  logic             rtc_enable,
  input  logic [BCD_W-1:0] rtc_hour_bcd,
  input  logic [BCD_W-1:0] rtc_minute_bcd,
  input  logic [BCD_W-1:0] rtc_second_bcd,
  output tick_res_t        res
);

  tod_t inc;
  logic roll;

  always_comb begin
    inc = cur;
    roll = 1'b0;
    if (cur.second >= SEC_MAX) begin
      inc.second = '0;
      roll = 1'b1;
      if (cur.minute >= MIN_MAX) begin
        inc.minute = '0;
        inc.hour = (cur.hour >= HOUR_MAX) ? '0 : cur.hour + HOUR_W'(1);
      end else begin
        inc.minute = cur.minute + MIN_W'(1);
      end
    end else begin
      inc.second = cur.second + SEC_W'(1);
    end
  end

  always_comb begin
    res.tod = cur;
    res.minute_roll = 1'b0;
    if (operation == OP_TICK) begin
      res.tod = inc;
      res.minute_roll = roll;
      if (rtc_enable && inc.second == SEC_RESYNC) begin
        res.tod.hour = HOUR_W'(bcd_dec(rtc_hour_bcd, BCD_W'(HOUR_MAX)));
        res.tod.minute = MIN_W'(bcd_dec(rtc_minute_bcd, BCD_W'(MIN_MAX)));
        res.tod.second = SEC_W'(bcd_dec(rtc_second_bcd, BCD_W'(SEC_MAX)));
      end
    end
  end

endmodule

// ===== rtl/tdcfa_alarm.sv =====
// Alarm compare: first armed alarm with nonzero feed matching hour and minute.
module tdcfa_alarm
  import tdcfa_pkg::*;
#(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  logic [NUM_ALARMS-1:0][ALARM_W-1:0] alarm_words,
  input  tod_t                               tod,
  output match_t                             match
);

  alarm_t a;

  always_comb begin
    match = '0;
    a = '0;
    // lowest index wins: scan from the top down
    for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
      a = alarm_t'(alarm_words[i]);
      if (a.armed && a.hour == tod.hour && a.minute == tod.minute && a.feed != '0) begin
        match.fired = 1'b1;
        match.amount = a.feed;
      end
    end
  end

endmodule

// ===== rtl/time_of_day_clock_with_feed_alarms.sv =====
// Throughput: one item per cycle while out_ready allows; input register, then time and alarm logic
// into the result register, which holds a result while the next item enters.
// Reset: synchronous active-low; time, feed flag, config and valids clear to 0.
`include "assert_macros.svh"
module time_of_day_clock_with_feed_alarms
  import tdcfa_pkg::*;
#(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ALARM_W-1:0]   cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_operation,
  input  logic [BCD_W-1:0]     in_rtc_hour_bcd,
  input  logic [BCD_W-1:0]     in_rtc_minute_bcd,
  input  logic [BCD_W-1:0]     in_rtc_second_bcd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [HOUR_W-1:0]    out_hour_now,
  output logic [MIN_W-1:0]     out_minute_now,
  output logic [SEC_W-1:0]     out_second_now,
  output logic                 out_feed_active,
  output logic                 out_fired,
  output logic [FEED_W-1:0]    out_feed_amount
);

  logic                              rtc_en_r;
  logic [NUM_ALARMS-1:0][ALARM_W-1:0] alarm_r;

  logic             in_vld_r;
  logic             op_r;
  logic [BCD_W-1:0] hbcd_r, mbcd_r, sbcd_r;

  tod_t tod_r;
  logic flag_r;
  logic flag_nxt;

  logic             out_vld_r;
  tod_t             out_tod_r;
  logic             out_flag_r;
  match_t           out_match_r;

  tick_res_t tres;
  match_t    mres;
  logic      advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rtc_en_r <= 1'b0;
      alarm_r  <= '0;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_RTC_EN) begin
        rtc_en_r <= cfg_wdata[0];
      end
      for (int i = 0; i < NUM_ALARMS; i++) begin
        if (cfg_index == CFG_IDX_W'(int'(REG_ALARM_BASE) + i)) begin
          alarm_r[i] <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r   <= in_operation;
      hbcd_r <= in_rtc_hour_bcd;
      mbcd_r <= in_rtc_minute_bcd;
      sbcd_r <= in_rtc_second_bcd;
    end
  end

  tdcfa_time u_time (
    .cur            (tod_r),
    .operation      (op_r),
    .rtc_enable     (rtc_en_r),
    .rtc_hour_bcd   (hbcd_r),
    .rtc_minute_bcd (mbcd_r),
    .rtc_second_bcd (sbcd_r),
    .res            (tres)
  );

  tdcfa_alarm #(
    .NUM_ALARMS (NUM_ALARMS)
  ) u_alarm (
    .alarm_words (alarm_r),
    .tod         (tres.tod),
    .match       (mres)
  );

  assign flag_nxt = mres.fired ? 1'b1 : (tres.minute_roll ? 1'b0 : flag_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r  <= '0;
      flag_r <= 1'b0;
    end else if (advance) begin
      tod_r  <= tres.tod;
      flag_r <= flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tod_r   <= tres.tod;
      out_flag_r  <= flag_nxt;
      out_match_r <= mres;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_hour_now    = out_tod_r.hour;
  assign out_minute_now  = out_tod_r.minute;
  assign out_second_now  = out_tod_r.second;
  assign out_feed_active = out_flag_r;
  assign out_fired       = out_match_r.fired;
  assign out_feed_amount = out_match_r.amount;

  `ASSERT_IMPLY(a_fired_amount, clk, rst_n, out_vld_r && out_match_r.fired,
                out_match_r.amount != '0, "fired with zero feed amount")
  `ASSERT_IMPLY(a_idle_amount, clk, rst_n, out_vld_r && !out_match_r.fired,
                out_match_r.amount == '0, "feed amount without a fired alarm")
  `ASSERT_IMPLY(a_fired_flag, clk, rst_n, out_vld_r && out_match_r.fired,
                out_flag_r, "alarm fired but feed flag clear")
  `ASSERT_ALWAYS(a_tod_range, clk, rst_n,
                 tod_r.hour <= HOUR_MAX && tod_r.minute <= MIN_MAX && tod_r.second <= SEC_MAX,
                 "time of day out of range")
  `ASSERT_IMPLY(a_ready_free, clk, rst_n, !out_vld_r, in_ready,
                "input stalled while result register empty")

endmodule

// ===== tb/time_of_day_clock_with_feed_alarms_tb.sv =====
// Testbench for the time-of-day clock with feed alarms: predictor, stimulus and result checks.
module time_of_day_clock_with_feed_alarms_tb
  import tdcfa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              flag;
    logic              fired;
    logic [FEED_W-1:0] amount;
  } tod_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ALARM_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_operation = OP_TICK;
  logic [BCD_W-1:0]     in_rtc_hour_bcd = '0;
  logic [BCD_W-1:0]     in_rtc_minute_bcd = '0;
  logic [BCD_W-1:0]     in_rtc_second_bcd = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [HOUR_W-1:0]    out_hour_now;
  logic [MIN_W-1:0]     out_minute_now;
  logic [SEC_W-1:0]     out_second_now;
  logic                 out_feed_active;
  logic                 out_fired;
  logic [FEED_W-1:0]    out_feed_amount;

  time_of_day_clock_with_feed_alarms u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_rtc_hour_bcd   (in_rtc_hour_bcd),
    .in_rtc_minute_bcd (in_rtc_minute_bcd),
    .in_rtc_second_bcd (in_rtc_second_bcd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hour_now      (out_hour_now),
    .out_minute_now    (out_minute_now),
    .out_second_now    (out_second_now),
    .out_feed_active   (out_feed_active),
    .out_fired         (out_fired),
    .out_feed_amount   (out_feed_amount)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  tod_t        clock_q = '0;
  logic        feed_flag_q = 1'b0;
  logic        rtc_en_q = 1'b0;
  alarm_t      alarm_q [NUM_ALARMS_DEF];
  tod_result_t expected_q [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  initial begin
    for (int i = 0; i < NUM_ALARMS_DEF; i++) alarm_q[i] = '0;
  end

  function automatic int unsigned bcd_value(logic [7:0] v, int unsigned cap);
    int unsigned d;
    d = int'(v[7:4]) * 10 + int'(v[3:0]);
    return (d > cap) ? cap : d;
  endfunction

  function automatic logic [7:0] to_bcd(int unsigned n);
    return {4'(n / 10), 4'(n % 10)};
  endfunction

  function automatic logic [ALARM_W-1:0] alarm_word(int unsigned h, int unsigned m,
                                                    logic armed, logic [7:0] feed);
    return {feed, armed, 6'(m), 5'(h)};
  endfunction

  function automatic tod_result_t step_clock(logic op, logic [7:0] hb, logic [7:0] mb,
                                             logic [7:0] sb);
    tod_result_t r;
    alarm_t      a;
    r = '0;
    if (op == OP_TICK) begin
      if (clock_q.second >= SEC_MAX) begin
        clock_q.second = '0;
        feed_flag_q = 1'b0;
        if (clock_q.minute >= MIN_MAX) begin
          clock_q.minute = '0;
          clock_q.hour = (clock_q.hour >= HOUR_MAX) ? '0 : clock_q.hour + 1'b1;
        end else begin
          clock_q.minute = clock_q.minute + 1'b1;
        end
      end else begin
        clock_q.second = clock_q.second + 1'b1;
      end
      if (rtc_en_q && clock_q.second == SEC_RESYNC) begin
        clock_q.hour = HOUR_W'(bcd_value(hb, HOUR_MAX));
        clock_q.minute = MIN_W'(bcd_value(mb, MIN_MAX));
        clock_q.second = SEC_W'(bcd_value(sb, SEC_MAX));
      end
    end
    for (int i = 0; i < NUM_ALARMS_DEF; i++) begin
      a = alarm_q[i];
      if (!r.fired && a.armed && a.hour == clock_q.hour && a.minute == clock_q.minute &&
          a.feed != '0) begin
        feed_flag_q = 1'b1;
        r.fired = 1'b1;
        r.amount = a.feed;
      end
    end
    r.hour = clock_q.hour;
    r.minute = clock_q.minute;
    r.second = clock_q.second;
    r.flag = feed_flag_q;
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  task automatic send_item(input logic op, input logic [7:0] hb, input logic [7:0] mb,
                           input logic [7:0] sb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_rtc_hour_bcd <= hb;
    in_rtc_minute_bcd <= mb;
    in_rtc_second_bcd <= sb;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(step_clock(op, hb, mb, sb));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    @(negedge clk);
  endtask

  task automatic apply_config(input logic en, input logic [ALARM_W-1:0] w1,
                              input logic [ALARM_W-1:0] w2, input logic [ALARM_W-1:0] w3);
    logic [ALARM_W-1:0] vals [4];
    vals[0] = {{(ALARM_W-1){1'b0}}, en};
    vals[1] = w1;
    vals[2] = w2;
    vals[3] = w3;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= (i == 0) ? REG_RTC_EN : REG_ALARM_BASE + CFG_IDX_W'(i - 1);
      cfg_wdata <= vals[i];
      if (i == 0) rtc_en_q = vals[0][0];
      else alarm_q[i-1] = vals[i];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    tod_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("hour_now", want.hour, out_hour_now);
        check_field("minute_now", want.minute, out_minute_now);
        check_field("second_now", want.second, out_second_now);
        check_field("feed_active", want.flag, out_feed_active);
        check_field("fired", want.fired, out_fired);
        check_field("feed_amount", want.amount, out_feed_amount);
      end
    end
  end

  task automatic test_reset_state();
    send_item(OP_CHECK, 8'h00, 8'h00, 8'h00);
  endtask

  // Count up to second 45 and load from the BCD fields
  task automatic test_resync_load();
    apply_config(1'b1, '0, '0, '0);
    repeat (44) send_item(OP_TICK, 8'h12, 8'h34, 8'h56);
    send_item(OP_TICK, 8'h23, 8'h59, 8'h44);
  endtask

  // Second 44 keeps reloading on every tick; nibbles above 9 and saturation
  task automatic test_bad_bcd();
    send_item(OP_TICK, 8'hFF, 8'hFF, 8'h3E);
    send_item(OP_TICK, 8'h0F, 8'h4C, 8'h3E);
    send_item(OP_TICK, 8'h24, 8'h60, 8'h3E);
    send_item(OP_TICK, 8'h99, 8'h99, 8'h44);
  endtask

  task automatic test_alarm_priority();
    apply_config(1'b1, alarm_word(23, 59, 1'b1, 8'h00), alarm_word(23, 59, 1'b0, 8'hFF),
                 alarm_word(23, 59, 1'b1, 8'hFF));
    send_item(OP_CHECK, 8'h00, 8'h00, 8'h00);
    send_item(OP_CHECK, 8'hFF, 8'hFF, 8'hFF);
    send_item(OP_TICK, 8'h23, 8'h59, 8'h44);
    apply_config(1'b1, alarm_word(23, 59, 1'b1, 8'h01), 20'hFFFFF,
                 alarm_word(23, 59, 1'b1, 8'h80));
    send_item(OP_CHECK, 8'h00, 8'h00, 8'h00);
    apply_config(1'b1, 20'hFFFFF, alarm_word(23, 63, 1'b1, 8'h10),
                 alarm_word(31, 59, 1'b1, 8'h20));
    send_item(OP_CHECK, 8'h00, 8'h00, 8'h00);
  endtask

  // Hour and minute wrap; rollover clears the flag, then an alarm at 00:00 sets it
  task automatic test_rollover();
    apply_config(1'b1, '0, '0, '0);
    send_item(OP_TICK, 8'h23, 8'h59, 8'h58);
    send_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00, 8'h00);
    apply_config(1'b0, alarm_word(0, 0, 1'b1, 8'h80), '0, '0);
    send_item(OP_CHECK, 8'h00, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00, 8'h00);
  endtask

  function automatic logic [ALARM_W-1:0] random_alarm(int unsigned th, int unsigned tm);
    int unsigned h, m;
    logic [7:0]  feed;
    if ($urandom_range(0, 9) >= 7) return ALARM_W'($urandom);
    h = ($urandom_range(0, 4) == 0) ? (th + 1) % 24 : th;
    case ($urandom_range(0, 2))
      0: m = tm;
      1: m = (tm + 1) % 60;
      default: m = $urandom_range(0, 59);
    endcase
    feed = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
    return alarm_word(h, m, $urandom_range(0, 4) != 0, feed);
  endfunction

  task automatic test_random_traffic();
    int          sent;
    int          n;
    int unsigned th, tm, ts;
    logic        op;
    logic [7:0]  hb, mb, sb;
    sent = 0;
    while (sent < 390) begin
      idle_on = ($urandom_range(0, 3) != 0);
      th = ($urandom_range(0, 3) == 0) ? 23 : $urandom_range(0, 23);
      tm = ($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59);
      apply_config($urandom_range(0, 4) != 0, random_alarm(th, tm), random_alarm(th, tm),
                   random_alarm(th, tm));
      n = $urandom_range(10, 40);
      repeat (n) begin
        op = ($urandom_range(0, 4) == 0) ? OP_CHECK : OP_TICK;
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 3))
            0: ts = 44;
            1: ts = 58;
            2: ts = 59;
            default: ts = $urandom_range(0, 59);
          endcase
          hb = to_bcd(th);
          mb = to_bcd(tm);
          sb = to_bcd(ts);
        end else begin
          {hb, mb, sb} = 24'($urandom);
        end
        send_item(op, hb, mb, sb);
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_resync_load();
    test_bad_bcd();
    test_alarm_priority();
    test_rollover();
    test_random_traffic();
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("time_of_day_clock_with_feed_alarms_tb OK");
    end else begin
      $display("time_of_day_clock_with_feed_alarms_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("time_of_day_clock_with_feed_alarms_tb NOT OK");
    $finish;
  end

endmodule
